/* sv/psmac_pkg.sv */
`timescale 1ns / 1ps

package psmac_pkg;

    // fixed word sizes of the datapath
    localparam int WORD_BITS = 32;
    localparam int ACC_BITS  = 2 * WORD_BITS;
    localparam int NUM_MODES = 5;

    // lane width codes
    typedef enum logic [2:0] {
        MODE_LANE2  = 3'd0,
        MODE_LANE4  = 3'd1,
        MODE_LANE8  = 3'd2,
        MODE_LANE16 = 3'd3,
        MODE_LANE32 = 3'd4
    } lane_mode_t;

    localparam lane_mode_t MODE_RESET = MODE_LANE8;

    // request kinds
    typedef enum logic {
        REQ_MAC  = 1'b0,
        REQ_READ = 1'b1
    } req_kind_t;

    // product stage handed to the accumulator
    typedef struct packed {
        logic                valid;
        req_kind_t           kind;
        logic [ACC_BITS-1:0] prod;
    } psmac_stage_t;

endpackage

/* sv/psmac_req_if.sv */
`timescale 1ns / 1ps

interface psmac_req_if import psmac_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [WORD_BITS-1:0] operand_a;
    logic [WORD_BITS-1:0] operand_b;

    modport source (output valid, req_type, operand_a, operand_b, input ready);
    modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

/* sv/psmac_rsp_if.sv */
`timescale 1ns / 1ps

interface psmac_rsp_if import psmac_pkg::*; ();
    logic                        valid;
    logic                        ready;
    logic signed [WORD_BITS-1:0] read_value;

    modport source (output valid, read_value, input ready);
    modport sink   (input valid, read_value, output ready);
endinterface

/* sv/psmac_lane_mult.sv */
`timescale 1ns / 1ps

module psmac_lane_mult import psmac_pkg::*; (
    input  logic [WORD_BITS-1:0] a,
    input  logic [WORD_BITS-1:0] b,
    input  lane_mode_t           mode,
    output logic [ACC_BITS-1:0]  prod
);

    logic [ACC_BITS-1:0] mode_prod [NUM_MODES];

    // one bank of signed lane multipliers per lane width
    for (genvar m = 0; m < NUM_MODES; m++)
    begin : g_mode
        localparam int W = 2 << m;
        localparam int N = WORD_BITS / W;
        for (genvar i = 0; i < N; i++)
        begin : g_lane
            logic signed [2*W-1:0] p;
            assign p = $signed(a[W*i +: W]) * $signed(b[W*i +: W]);
            assign mode_prod[m][2*W*i +: 2*W] = p;
        end
    end

    // pick the packed word for the active lane width
    always_comb
    begin
        case (mode)
            MODE_LANE2:  prod = mode_prod[0];
            MODE_LANE4:  prod = mode_prod[1];
            MODE_LANE8:  prod = mode_prod[2];
            MODE_LANE16: prod = mode_prod[3];
            MODE_LANE32: prod = mode_prod[4];
            default:     prod = '0;
        endcase
    end

endmodule

/* sv/psmac_accum.sv */
`timescale 1ns / 1ps

module psmac_accum import psmac_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  psmac_stage_t       stage,
    output logic               take,
    psmac_rsp_if.source        rsp
);

    logic [ACC_BITS-1:0]  acc_reg;
    logic [ACC_BITS-1:0]  acc_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_BITS-1:0] out_data_reg;
    logic                 out_free;
    logic                 fire;
    logic                 fire_read;

    // macs always drain, reads wait for the output slot
    assign out_free  = !out_valid_reg || rsp.ready;
    assign take      = (stage.kind == REQ_MAC) || out_free;
    assign fire      = stage.valid && take;
    assign fire_read = fire && (stage.kind == REQ_READ);

    // accumulate or clear
    always_comb
    begin
        acc_next = acc_reg;
        if (fire)
        begin
            if (stage.kind == REQ_READ)
                acc_next = '0;
            else
                acc_next = acc_reg + stage.prod;
        end
    end

    // output slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire_read)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // low half captured before the clear
    always_ff @(posedge clk)
    begin
        if (fire_read)
            out_data_reg <= acc_reg[WORD_BITS-1:0];
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.read_value = $signed(out_data_reg);

endmodule

/* sv/packed_simd_mac_unit.sv */
`timescale 1ns / 1ps
// packed simd multiply-accumulate unit
// a read request passes the input and product registers, and its result is then captured in the output register
// throughput: one request per cycle unless a waiting result stalls, set by the input, product and accumulator registers
// a waiting result stalls a read at the accumulator and every request queued behind it
// reset: asynchronous active low, clears the accumulator to zero and sets 8-bit lanes

module packed_simd_mac_unit import psmac_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    psmac_req_if.sink   req,
    psmac_rsp_if.source rsp
);

    lane_mode_t           mode_reg;
    logic                 s1_valid_reg;
    req_kind_t            s1_kind_reg;
    logic [WORD_BITS-1:0] s1_a_reg;
    logic [WORD_BITS-1:0] s1_b_reg;
    logic                 s2_valid_reg;
    req_kind_t            s2_kind_reg;
    logic [ACC_BITS-1:0]  s2_prod_reg;
    logic [ACC_BITS-1:0]  prod;
    logic                 s1_ready;
    logic                 s2_ready;
    logic                 take;
    psmac_stage_t         stage;

    // lane width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_RESET;
        else if (cfg_wr_en)
            mode_reg <= lane_mode_t'(cfg_wr_data);
    end

    // ready chain back from the accumulator
    assign s2_ready  = !s2_valid_reg || take;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign req.ready = s1_ready;

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= req.valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_kind_reg <= req_kind_t'(req.req_type);
            s1_a_reg    <= req.operand_a;
            s1_b_reg    <= req.operand_b;
        end
    end

    psmac_lane_mult u_lane_mult (
        .a    (s1_a_reg),
        .b    (s1_b_reg),
        .mode (mode_reg),
        .prod (prod)
    );

    // product register
    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_kind_reg <= s1_kind_reg;
            s2_prod_reg <= prod;
        end
    end

    assign stage.valid = s2_valid_reg;
    assign stage.kind  = s2_kind_reg;
    assign stage.prod  = s2_prod_reg;

    psmac_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .stage (stage),
        .take  (take),
        .rsp   (rsp)
    );

endmodule
